// ----- rtl/core/pbm_pkg.sv -----
package pbm_pkg;

    // Seconds per minute bank.
    localparam int SECOND_BINS = 100;
    localparam int BIN_DEPTH   = 2 * SECOND_BINS;
    localparam int ROW_W       = $clog2(BIN_DEPTH);
    localparam int SCNT_W      = $clog2(SECOND_BINS);

    localparam int BIN_W   = 40;
    localparam int BYTES_W = 16;
    localparam int BITS_W  = BYTES_W + 3;
    localparam int SECS_W  = 32;

    // Reciprocal for secs / SECOND_BINS; the estimate is low by at most one.
    localparam int RECIP_SHIFT = 37;
    localparam logic [SECS_W-1:0] RECIP =
        SECS_W'((64'd1 << RECIP_SHIFT) / SECOND_BINS);
    localparam int QUO_W = 2 * SECS_W - RECIP_SHIFT;

    // Command queue, power of two deep.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef struct packed {
        logic                  action;
        logic                  minute_parity;
        logic [BYTES_W-1:0]    frame_bytes;
        logic                  upstream;
        logic [SECS_W-1:0]     epoch_seconds;
    } pbm_in_t;

    typedef struct packed {
        logic [BIN_W-1:0] peak_total_bits;
        logic [BIN_W-1:0] peak_up_bits;
        logic [BIN_W-1:0] peak_down_bits;
    } pbm_out_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic              action;
        logic              parity;
        logic              upstream;
        logic [BITS_W-1:0] bits;
        logic [ROW_W-1:0]  row;
    } pbm_op_t;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
    } pbm_qstat_t;

endpackage

// ----- rtl/core/pbm_front.sv -----
module pbm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pbm_pkg::pbm_in_t    item,
    input  pbm_pkg::pbm_qstat_t qstat,
    output logic                busy,
    output logic                push,
    output pbm_pkg::pbm_op_t    push_op
);
    import pbm_pkg::*;

    logic              accept;
    logic [CNT_W:0]    load;

    logic              v1_reg, v1_next;
    logic [SECS_W-1:0] n1_reg;
    logic              act1_reg, par1_reg, up1_reg;
    logic [BITS_W-1:0] bits1_reg;

    logic              v2_reg, v2_next;
    logic [QUO_W-1:0]  q2_reg;
    logic [ROW_W-1:0]  nlow2_reg;
    logic              act2_reg, par2_reg, up2_reg;
    logic [BITS_W-1:0] bits2_reg;

    logic [2*SECS_W-1:0] prod;
    logic [ROW_W-1:0]    r0, rem, row;

    // Reserve a queue slot for every word still in the index pipeline.
    assign load   = (CNT_W+1)'(qstat.count) + (CNT_W+1)'(v1_reg) + (CNT_W+1)'(v2_reg);
    assign busy   = (load >= (CNT_W+1)'(QDEPTH));
    assign accept = start && !busy;

    assign v1_next = accept;
    assign v2_next = v1_reg;
    assign prod    = (2*SECS_W)'(n1_reg) * (2*SECS_W)'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n1_reg    <= item.epoch_seconds;
            act1_reg  <= item.action;
            par1_reg  <= item.minute_parity;
            up1_reg   <= item.upstream;
            bits1_reg <= {item.frame_bytes, 3'b000};
        end
        if (v1_reg)
        begin
            q2_reg    <= prod[RECIP_SHIFT +: QUO_W];
            nlow2_reg <= n1_reg[ROW_W-1:0];
            act2_reg  <= act1_reg;
            par2_reg  <= par1_reg;
            up2_reg   <= up1_reg;
            bits2_reg <= bits1_reg;
        end
    end

    // Remainder is below 2*SECOND_BINS, so low bits alone are exact.
    always_comb
    begin
        r0  = nlow2_reg - ROW_W'(q2_reg[ROW_W-1:0] * ROW_W'(SECOND_BINS));
        rem = (r0 >= ROW_W'(SECOND_BINS)) ? r0 - ROW_W'(SECOND_BINS) : r0;
        row = par2_reg ? rem + ROW_W'(SECOND_BINS) : rem;
    end

    assign push             = v2_reg;
    assign push_op.action   = act2_reg;
    assign push_op.parity   = par2_reg;
    assign push_op.upstream = up2_reg;
    assign push_op.bits     = bits2_reg;
    assign push_op.row      = row;

endmodule

// ----- rtl/core/pbm_queue.sv -----
module pbm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pbm_pkg::pbm_op_t    push_op,
    input  logic                pop,
    output pbm_pkg::pbm_op_t    head,
    output pbm_pkg::pbm_qstat_t qstat
);
    import pbm_pkg::*;

    pbm_op_t           q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_op;
    end

    assign head        = q_mem[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;

endmodule

// ----- rtl/core/pbm_back.sv -----
module pbm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pbm_pkg::pbm_op_t    head,
    input  pbm_pkg::pbm_qstat_t qstat,
    output logic                pop,
    output logic                done,
    output pbm_pkg::pbm_out_t   result
);
    import pbm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_SCAN} state_t;

    function automatic logic [BIN_W-1:0] sat_add(input logic [BIN_W-1:0] bin,
                                                 input logic [BITS_W-1:0] bits);
        logic [BIN_W:0] sum;
        sum = {1'b0, bin} + (BIN_W+1)'(bits);
        return sum[BIN_W] ? {BIN_W{1'b1}} : sum[BIN_W-1:0];
    endfunction

    function automatic logic [BIN_W-1:0] max40(input logic [BIN_W-1:0] a,
                                               input logic [BIN_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Bin memories: one row per second of both banks.
    logic [BIN_W-1:0] tot_mem [BIN_DEPTH];
    logic [BIN_W-1:0] up_mem  [BIN_DEPTH];
    logic [BIN_W-1:0] dn_mem  [BIN_DEPTH];

    state_t              state_reg, state_next;
    logic [BIN_DEPTH-1:0] valid_reg, valid_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic                cur_up_reg, cur_up_next;
    logic [BITS_W-1:0]   cur_bits_reg, cur_bits_next;
    logic [ROW_W-1:0]    scan_row_reg, scan_row_next;
    logic [SCNT_W-1:0]   scnt_reg, scnt_next;
    logic [BIN_W-1:0]    pk_tot_reg, pk_tot_next;
    logic [BIN_W-1:0]    pk_up_reg, pk_up_next;
    logic [BIN_W-1:0]    pk_dn_reg, pk_dn_next;
    logic                done_reg, done_next;
    pbm_out_t            res_reg, res_next;
    logic                wr_last_reg;
    logic [ROW_W-1:0]    wr_row_reg;
    logic [BIN_W-1:0]    fwd_tot_reg, fwd_up_reg, fwd_dn_reg;

    logic [BIN_W-1:0]    rd_tot_reg, rd_up_reg, rd_dn_reg;
    logic                rd_valid_reg;

    logic             pop_pkt, pop_rep, last, rd_en, wr_en, fwd_use;
    logic [ROW_W-1:0] rd_addr, rep_base;
    logic [BIN_W-1:0] old_tot, old_up, old_dn, new_tot, new_up, new_dn;

    always_comb
    begin
        pop_pkt = ((state_reg == S_IDLE) || (state_reg == S_UPD)) && !qstat.empty
                  && (head.action == ACT_PACKET);
        pop_rep = (state_reg == S_IDLE) && !qstat.empty && (head.action == ACT_REPORT);
        pop     = pop_pkt || pop_rep;
        last    = (scnt_reg == SCNT_W'(SECOND_BINS - 1));
        wr_en   = (state_reg == S_UPD);

        // A report reads the bank of the other minute.
        rep_base = head.parity ? '0 : ROW_W'(SECOND_BINS);

        rd_en   = pop || ((state_reg == S_SCAN) && !last);
        if (state_reg == S_SCAN)
            rd_addr = scan_row_reg + ROW_W'(1);
        else if (pop_rep)
            rd_addr = rep_base;
        else
            rd_addr = head.row;

        // Row written at the same edge as our read: take the written value.
        fwd_use = wr_last_reg && (wr_row_reg == cur_row_reg);
        if (fwd_use)
        begin
            old_tot = fwd_tot_reg;
            old_up  = fwd_up_reg;
            old_dn  = fwd_dn_reg;
        end
        else if (rd_valid_reg)
        begin
            old_tot = rd_tot_reg;
            old_up  = rd_up_reg;
            old_dn  = rd_dn_reg;
        end
        else
        begin
            old_tot = '0;
            old_up  = '0;
            old_dn  = '0;
        end

        new_tot = sat_add(old_tot, cur_bits_reg);
        new_up  = cur_up_reg ? sat_add(old_up, cur_bits_reg) : old_up;
        new_dn  = cur_up_reg ? old_dn : sat_add(old_dn, cur_bits_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        cur_row_next  = cur_row_reg;
        cur_up_next   = cur_up_reg;
        cur_bits_next = cur_bits_reg;
        scan_row_next = scan_row_reg;
        scnt_next     = scnt_reg;
        pk_tot_next   = pk_tot_reg;
        pk_up_next    = pk_up_reg;
        pk_dn_next    = pk_dn_reg;
        done_next     = 1'b0;
        res_next      = res_reg;

        if (wr_en)
            valid_next[cur_row_reg] = 1'b1;

        if (pop_pkt)
        begin
            cur_row_next  = head.row;
            cur_up_next   = head.upstream;
            cur_bits_next = head.bits;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (pop_pkt)
                    state_next = S_UPD;
                else if (pop_rep)
                begin
                    state_next    = S_SCAN;
                    scan_row_next = rep_base;
                    scnt_next     = '0;
                    pk_tot_next   = '0;
                    pk_up_next    = '0;
                    pk_dn_next    = '0;
                end
            end
            S_UPD:
            begin
                if (!pop_pkt)
                    state_next = S_IDLE;
            end
            S_SCAN:
            begin
                pk_tot_next = max40(pk_tot_reg, old_tot);
                pk_up_next  = max40(pk_up_reg, old_up);
                pk_dn_next  = max40(pk_dn_reg, old_dn);
                valid_next[scan_row_reg] = 1'b0;
                if (last)
                begin
                    state_next               = S_IDLE;
                    done_next                = 1'b1;
                    res_next.peak_total_bits = pk_tot_next;
                    res_next.peak_up_bits    = pk_up_next;
                    res_next.peak_down_bits  = pk_dn_next;
                end
                else
                begin
                    scan_row_next = scan_row_reg + ROW_W'(1);
                    scnt_next     = scnt_reg + SCNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
            wr_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            wr_last_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_row_reg  <= cur_row_next;
        cur_up_reg   <= cur_up_next;
        cur_bits_reg <= cur_bits_next;
        scan_row_reg <= scan_row_next;
        scnt_reg     <= scnt_next;
        pk_tot_reg   <= pk_tot_next;
        pk_up_reg    <= pk_up_next;
        pk_dn_reg    <= pk_dn_next;
        res_reg      <= res_next;
        if (wr_en)
        begin
            wr_row_reg  <= cur_row_reg;
            fwd_tot_reg <= new_tot;
            fwd_up_reg  <= new_up;
            fwd_dn_reg  <= new_dn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tot_mem[cur_row_reg] <= new_tot;
            up_mem[cur_row_reg]  <= new_up;
            dn_mem[cur_row_reg]  <= new_dn;
        end
        if (rd_en)
        begin
            rd_tot_reg   <= tot_mem[rd_addr];
            rd_up_reg    <= up_mem[rd_addr];
            rd_dn_reg    <= dn_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/core/peak_bandwidth_meter.sv -----
// Peak bandwidth meter for one interface. Present a word on item with start
// high; it is taken at the clock edge where start is high and busy is low. A
// packet word (action = 0) adds frame_bytes*8 to the per-second bin at
// epoch_seconds mod 100 in the bank of the current minute parity; it never
// produces a result. A minute-end word (action = 1) scans the opposite bank,
// clears it, and returns the peak total, upstream and downstream bits per
// second as a single-cycle done strobe with result updated in that cycle:
// there is no back-pressure on results, so capture them when done is high.
// Bins saturate at 2^40-1 and read as zero after reset with no clearing pass
// (per-row valid flops). Packets are sustained at one per cycle, unless a scan
// fills the queue, through a two-stage index pipeline (reciprocal multiply for
// mod 100), a four-word command queue and a read-modify-write stage on the bin
// memories with write forwarding; with the back end idle a packet's bin is
// written after the index pipeline, the queue and the bin read. A report holds
// the single memory read port while it scans the bank; with the back end idle
// its done strobe follows the index pipeline, the queue and the scan. Words
// keep being taken during a scan until the queue fills, then busy stays high
// until the scan frees a slot.
module peak_bandwidth_meter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pbm_pkg::pbm_in_t  item,
    output logic              busy,
    output logic              done,
    output pbm_pkg::pbm_out_t result
);
    import pbm_pkg::*;

    // Front to queue
    logic       push;
    pbm_op_t    push_op;
    // Queue to back
    pbm_op_t    head;
    pbm_qstat_t qstat;
    logic       pop;

    // Front: takes words, computes the bin row, reserves queue space.
    pbm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .qstat   (qstat),
        .busy    (busy),
        .push    (push),
        .push_op (push_op)
    );

    // Short queue decouples word intake from the memory sequencer.
    pbm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .qstat   (qstat)
    );

    // Back: bin updates and minute-end peak scan.
    pbm_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// ----- rtl/core/pbm_checker.sv -----
module pbm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              done,
    input pbm_pkg::pbm_out_t result
);

    // Queue and pipeline are empty right after reset.
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !busy)
        else $error("busy high right after reset");

    // A scan spans many cycles, so strobes are well apart.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ##1 !done ##1 !done)
        else $error("done strobes too close");

    // Every bin's up and down share never exceeds its total.
    a_up_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.peak_up_bits <= result.peak_total_bits))
        else $error("peak up exceeds peak total");

    a_down_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.peak_down_bits <= result.peak_total_bits))
        else $error("peak down exceeds peak total");

    // Handshake lines and a strobed result are always fully known.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({busy, done}) && (!done || !$isunknown(result)))
        else $error("unknown value on busy, done or result");

endmodule

bind peak_bandwidth_meter pbm_checker u_pbm_checker (.*);
